// ----- design/sls_pkg.sv -----
package sls_pkg;

  // Token codes on token_kind
  localparam logic [5:0] TK_SEMI      = 6'd0;
  localparam logic [5:0] TK_COMMA     = 6'd1;
  localparam logic [5:0] TK_PLUS      = 6'd2;
  localparam logic [5:0] TK_MINUS     = 6'd3;
  localparam logic [5:0] TK_STAR      = 6'd4;
  localparam logic [5:0] TK_SLASH     = 6'd5;
  localparam logic [5:0] TK_LPAR      = 6'd6;
  localparam logic [5:0] TK_RPAR      = 6'd7;
  localparam logic [5:0] TK_IF        = 6'd8;
  localparam logic [5:0] TK_VAR       = 6'd9;
  localparam logic [5:0] TK_TRUE      = 6'd10;
  localparam logic [5:0] TK_FALSE     = 6'd11;
  localparam logic [5:0] TK_OR        = 6'd12;
  localparam logic [5:0] TK_AND       = 6'd13;
  localparam logic [5:0] TK_LOG_OR    = 6'd14;
  localparam logic [5:0] TK_LOG_AND   = 6'd15;
  localparam logic [5:0] TK_NOT       = 6'd16;
  localparam logic [5:0] TK_NOT_EQ    = 6'd17;
  localparam logic [5:0] TK_ASSIGN    = 6'd18;
  localparam logic [5:0] TK_GT        = 6'd19;
  localparam logic [5:0] TK_GT_EQ     = 6'd20;
  localparam logic [5:0] TK_EQ        = 6'd21;
  localparam logic [5:0] TK_LT_EQ     = 6'd22;
  localparam logic [5:0] TK_LT        = 6'd23;
  localparam logic [5:0] TK_LCURLY    = 6'd25;
  localparam logic [5:0] TK_RCURLY    = 6'd26;
  localparam logic [5:0] TK_LSQUARE   = 6'd27;
  localparam logic [5:0] TK_RSQUARE   = 6'd28;
  localparam logic [5:0] TK_DQUOTE    = 6'd29;
  localparam logic [5:0] TK_SQUOTE    = 6'd30;
  localparam logic [5:0] TK_INPUT     = 6'd31;
  localparam logic [5:0] TK_OUTPUT    = 6'd32;
  localparam logic [5:0] TK_WORD_CHAR = 6'd33;
  localparam logic [5:0] TK_WORD_END  = 6'd34;

  // Most results one byte can cause
  localparam int MAX_RES = 8;

  typedef enum logic [2:0] {
    CAND_NONE   = 3'd0,
    CAND_VAR    = 3'd1,
    CAND_IF     = 3'd2,
    CAND_TRUE   = 3'd3,
    CAND_FALSE  = 3'd4,
    CAND_ALERT  = 3'd5,
    CAND_PROMPT = 3'd6
  } cand_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_OR   = 3'd1,
    OP_AND  = 3'd2,
    OP_EQ   = 3'd3,
    OP_NOT  = 3'd4,
    OP_LT   = 3'd5,
    OP_GT   = 3'd6
  } op_t;

  typedef struct packed {
    cand_t      cand;
    logic [2:0] mlen;
    op_t        op;
    logic       in_word;
    logic       if_space;
  } lex_state_t;

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] value;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] list;
    logic [3:0]         count;
  } step_out_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] kind;
  } tok_t;

  // Keyword text, left aligned, zero padded
  function automatic logic [63:0] kw_text(cand_t k);
    unique case (k)
      CAND_VAR:    return {"var ", 32'h0};
      CAND_IF:     return {"if", 48'h0};
      CAND_TRUE:   return {"true", 32'h0};
      CAND_FALSE:  return {"false", 24'h0};
      CAND_ALERT:  return {"alert", 24'h0};
      CAND_PROMPT: return {"prompt(", 8'h0};
      default:     return 64'h0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(cand_t k, logic [2:0] j);
    logic [63:0] t;
    logic [5:0]  pos;
    t   = kw_text(k);
    pos = {3'd7 - j, 3'b000};
    return t[pos +: 8];
  endfunction

  function automatic logic [2:0] kw_len(cand_t k);
    unique case (k)
      CAND_VAR:    return 3'd4;
      CAND_IF:     return 3'd2;
      CAND_TRUE:   return 3'd4;
      CAND_FALSE:  return 3'd5;
      CAND_ALERT:  return 3'd5;
      CAND_PROMPT: return 3'd7;
      default:     return 3'd0;
    endcase
  endfunction

  function automatic logic [5:0] kw_token(cand_t k);
    unique case (k)
      CAND_VAR:    return TK_VAR;
      CAND_IF:     return TK_IF;
      CAND_TRUE:   return TK_TRUE;
      CAND_FALSE:  return TK_FALSE;
      CAND_ALERT:  return TK_OUTPUT;
      CAND_PROMPT: return TK_INPUT;
      default:     return TK_SEMI;
    endcase
  endfunction

  // Matched prefix length, clipped to the keyword length
  function automatic logic [2:0] prefix_len(cand_t k, logic [2:0] n);
    logic [2:0] len;
    len = kw_len(k);
    return (n < len) ? n : len;
  endfunction

  function automatic cand_t cand_of(logic [7:0] c);
    unique case (c)
      "v":     return CAND_VAR;
      "i":     return CAND_IF;
      "t":     return CAND_TRUE;
      "f":     return CAND_FALSE;
      "a":     return CAND_ALERT;
      "p":     return CAND_PROMPT;
      default: return CAND_NONE;
    endcase
  endfunction

  function automatic op_t op_of(logic [7:0] c);
    unique case (c)
      "|":     return OP_OR;
      "&":     return OP_AND;
      "=":     return OP_EQ;
      "!":     return OP_NOT;
      "<":     return OP_LT;
      ">":     return OP_GT;
      default: return OP_NONE;
    endcase
  endfunction

  function automatic logic [7:0] op_partner(op_t p);
    unique case (p)
      OP_OR:   return "|";
      OP_AND:  return "&";
      OP_EQ,
      OP_NOT,
      OP_LT,
      OP_GT:   return "=";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [5:0] op_single(op_t p);
    unique case (p)
      OP_OR:   return TK_OR;
      OP_AND:  return TK_AND;
      OP_EQ:   return TK_ASSIGN;
      OP_NOT:  return TK_NOT;
      OP_LT:   return TK_LT;
      OP_GT:   return TK_GT;
      default: return TK_SEMI;
    endcase
  endfunction

  function automatic logic [5:0] op_double(op_t p);
    unique case (p)
      OP_OR:   return TK_LOG_OR;
      OP_AND:  return TK_LOG_AND;
      OP_EQ:   return TK_EQ;
      OP_NOT:  return TK_NOT_EQ;
      OP_LT:   return TK_LT_EQ;
      OP_GT:   return TK_GT_EQ;
      default: return TK_SEMI;
    endcase
  endfunction

  function automatic tok_t single_token(logic [7:0] c);
    unique case (c)
      ";":     return '{hit: 1'b1, kind: TK_SEMI};
      ",":     return '{hit: 1'b1, kind: TK_COMMA};
      "+":     return '{hit: 1'b1, kind: TK_PLUS};
      "-":     return '{hit: 1'b1, kind: TK_MINUS};
      "*":     return '{hit: 1'b1, kind: TK_STAR};
      "/":     return '{hit: 1'b1, kind: TK_SLASH};
      "(":     return '{hit: 1'b1, kind: TK_LPAR};
      ")":     return '{hit: 1'b1, kind: TK_RPAR};
      "{":     return '{hit: 1'b1, kind: TK_LCURLY};
      "}":     return '{hit: 1'b1, kind: TK_RCURLY};
      "[":     return '{hit: 1'b1, kind: TK_LSQUARE};
      "]":     return '{hit: 1'b1, kind: TK_RSQUARE};
      "\"":    return '{hit: 1'b1, kind: TK_DQUOTE};
      "'":     return '{hit: 1'b1, kind: TK_SQUOTE};
      default: return '{hit: 1'b0, kind: TK_SEMI};
    endcase
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    unique case (c)
      " ", ";", ",", "+", "-", "*", "/", "|", "&", ">", "<", "=",
      "{", "}", "[", "]", ")", "(", "\"", "'": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

// ----- design/sls_if.sv -----
interface sls_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source(output valid, output char_code, output end_of_text, input ready);
  modport sink(input valid, input char_code, input end_of_text, output ready);
endinterface

interface sls_token_if;
  logic       valid;
  logic       ready;
  logic [5:0] token_kind;
  logic [7:0] char_value;
  logic       last_of_run;

  modport source(output valid, output token_kind, output char_value, output last_of_run,
                 input ready);
  modport sink(input valid, input token_kind, input char_value, input last_of_run,
               output ready);
endinterface

// ----- design/sls_step.sv -----
module sls_step import sls_pkg::*; (
  input  lex_state_t cur,
  input  logic [7:0] chr,
  input  logic       eot,
  output lex_state_t nxt,
  output step_out_t  res
);

  // Segments of the result list, in output order:
  // op token, flushed prefix, up to two simple results, end prefix, end token
  logic       a_v;
  res_t       a_e;
  cand_t      b_k;
  logic [2:0] b_n;
  logic [1:0] c_n;
  res_t       c0;
  res_t       c1;
  cand_t      e_k;
  logic [2:0] e_n;
  logic       f_v;
  res_t       f_e;
  logic       run_mid;
  logic       run_fresh;
  lex_state_t s;

  logic       is_space;
  logic       delim;
  tok_t       f_tok;
  op_t        f_op;
  cand_t      f_cand;

  logic [4:0] o_b;
  logic [4:0] o_c;
  logic [4:0] o_e;
  logic [4:0] o_f;
  logic [4:0] total;

  // Classify the byte once
  assign is_space = (chr == " ");
  assign delim    = is_delim(chr);
  assign f_tok    = single_token(chr);
  assign f_op     = op_of(chr);
  assign f_cand   = cand_of(chr);

  // Walk the byte through the lexer state
  always_comb begin
    s         = cur;
    a_v       = 1'b0;
    a_e       = '0;
    b_k       = CAND_NONE;
    b_n       = 3'd0;
    c_n       = 2'd0;
    c0        = '0;
    c1        = '0;
    run_mid   = 1'b0;
    run_fresh = 1'b0;

    if (cur.op != OP_NONE) begin
      // complete or drop a pending operator
      s.op = OP_NONE;
      a_v  = 1'b1;
      if (chr == op_partner(cur.op)) begin
        a_e = '{kind: op_double(cur.op), value: 8'h00};
      end else begin
        a_e       = '{kind: op_single(cur.op), value: 8'h00};
        run_fresh = 1'b1;
      end
    end else if (cur.cand != CAND_NONE) begin
      if (cur.cand == CAND_IF && cur.mlen >= 3'd2) begin
        // "if" seen: wait for the parenthesis across spaces
        if (chr == "(") begin
          s.cand     = CAND_NONE;
          s.mlen     = 3'd0;
          s.if_space = 1'b0;
          c0         = '{kind: TK_IF, value: 8'h00};
          c1         = '{kind: TK_LPAR, value: 8'h00};
          c_n        = 2'd2;
        end else if (is_space) begin
          s.if_space = 1'b1;
        end else begin
          b_k        = cur.cand;
          b_n        = prefix_len(cur.cand, cur.mlen);
          s.cand     = CAND_NONE;
          s.mlen     = 3'd0;
          s.if_space = 1'b0;
          if (cur.if_space) begin
            c0        = '{kind: TK_WORD_END, value: 8'h00};
            c_n       = 2'd1;
            run_fresh = 1'b1;
          end else begin
            s.in_word = 1'b1;
            run_mid   = 1'b1;
          end
        end
      end else if (cur.mlen < kw_len(cur.cand) && kw_char(cur.cand, cur.mlen) == chr) begin
        // advance the keyword match
        s.mlen = cur.mlen + 3'd1;
        if ((cur.mlen + 3'd1) >= kw_len(cur.cand) && cur.cand != CAND_IF) begin
          s.cand     = CAND_NONE;
          s.mlen     = 3'd0;
          s.if_space = 1'b0;
          c0         = '{kind: kw_token(cur.cand), value: 8'h00};
          c_n        = 2'd1;
        end
      end else begin
        // failed match turns into a word
        b_k        = cur.cand;
        b_n        = prefix_len(cur.cand, cur.mlen);
        s.cand     = CAND_NONE;
        s.mlen     = 3'd0;
        s.if_space = 1'b0;
        s.in_word  = 1'b1;
        run_mid    = 1'b1;
      end
    end else if (cur.in_word) begin
      run_mid = 1'b1;
    end else begin
      run_fresh = 1'b1;
    end

    // Extend or close an open word
    if (run_mid) begin
      if (delim) begin
        c0        = '{kind: TK_WORD_END, value: 8'h00};
        c_n       = 2'd1;
        s.in_word = 1'b0;
        run_fresh = 1'b1;
      end else begin
        c0  = '{kind: TK_WORD_CHAR, value: chr};
        c_n = 2'd1;
      end
    end

    // Start something new from this byte
    if (run_fresh) begin
      priority if (is_space) begin
        s.if_space = s.if_space;
      end else if (f_tok.hit) begin
        if (c_n == 2'd0) c0 = '{kind: f_tok.kind, value: 8'h00};
        else c1 = '{kind: f_tok.kind, value: 8'h00};
        c_n = c_n + 2'd1;
      end else if (f_op != OP_NONE) begin
        s.op = f_op;
      end else if (f_cand != CAND_NONE) begin
        s.cand     = f_cand;
        s.mlen     = 3'd1;
        s.if_space = 1'b0;
      end else begin
        if (c_n == 2'd0) c0 = '{kind: TK_WORD_CHAR, value: chr};
        else c1 = '{kind: TK_WORD_CHAR, value: chr};
        c_n       = c_n + 2'd1;
        s.in_word = 1'b1;
      end
    end

    // Flush everything pending on the final byte
    e_k = CAND_NONE;
    e_n = 3'd0;
    f_v = 1'b0;
    f_e = '0;
    nxt = s;
    if (eot) begin
      if (s.op != OP_NONE) begin
        f_v = 1'b1;
        f_e = '{kind: op_single(s.op), value: 8'h00};
      end else if (s.cand != CAND_NONE) begin
        e_k = s.cand;
        e_n = prefix_len(s.cand, s.mlen);
        f_v = 1'b1;
        f_e = '{kind: TK_WORD_END, value: 8'h00};
      end else if (s.in_word) begin
        f_v = 1'b1;
        f_e = '{kind: TK_WORD_END, value: 8'h00};
      end
      nxt = '0;
    end
  end

  // Segment offsets in the result list
  assign o_b   = {4'b0, a_v};
  assign o_c   = o_b + {2'b0, b_n};
  assign o_e   = o_c + {3'b0, c_n};
  assign o_f   = o_e + {2'b0, e_n};
  assign total = o_f + {4'b0, f_v};

  // Place each result slot from its segment
  always_comb begin
    logic [4:0] pos;
    logic [4:0] rel;
    res.count = (total > 5'd8) ? 4'd8 : total[3:0];
    for (int i = 0; i < MAX_RES; i++) begin
      pos = 5'(i);
      rel = 5'd0;
      if (pos < o_b) begin
        res.list[i] = a_e;
      end else if (pos < o_c) begin
        rel         = pos - o_b;
        res.list[i] = '{kind: TK_WORD_CHAR, value: kw_char(b_k, rel[2:0])};
      end else if (pos < o_e) begin
        rel         = pos - o_c;
        res.list[i] = rel[0] ? c1 : c0;
      end else if (pos < o_f) begin
        rel         = pos - o_e;
        res.list[i] = '{kind: TK_WORD_CHAR, value: kw_char(e_k, rel[2:0])};
      end else begin
        res.list[i] = f_e;
      end
    end
  end

endmodule

// ----- design/script_lexer_stream.sv -----
// Streaming tokenizer: one source byte per transfer on chars, tokens out on
// tokens, each run of results for a byte ending with last_of_run set. An
// accepted byte waits in the input register until the burst buffer is free,
// then its whole result run (zero to eight results) is worked out in one
// pass and loaded into an eight-entry burst buffer that tokens drains one
// result per cycle while tokens is ready. The output port sets the rate: a
// byte that gives several results holds the next byte back until its last
// result is transferred, and with tokens ready and at most one result per
// byte the block takes a byte every cycle. A byte with end_of_text set also
// flushes pending operators, keyword prefixes and open words, and returns
// the lexer to its reset state.
module script_lexer_stream import sls_pkg::*; (
  input logic         clk,
  input logic         rst,
  sls_char_if.sink    chars,
  sls_token_if.source tokens
);

  logic       in_vld;
  logic [7:0] in_char;
  logic       in_eot;

  lex_state_t state;
  lex_state_t state_next;
  step_out_t  step;

  res_t       burst [MAX_RES];
  logic [3:0] burst_cnt;
  logic [2:0] burst_idx;

  logic       out_fire;
  logic       out_last;
  logic       burst_free;
  logic       take;

  sls_step u_step (
    .cur (state),
    .chr (in_char),
    .eot (in_eot),
    .nxt (state_next),
    .res (step)
  );

  // Handshake: the burst frees up on the transfer of its last result
  assign out_fire   = tokens.valid && tokens.ready;
  assign out_last   = ({1'b0, burst_idx} == (burst_cnt - 4'd1));
  assign burst_free = (burst_cnt == 4'd0) || (out_fire && out_last);
  assign take       = in_vld && burst_free;
  assign chars.ready = !in_vld || take;

  assign tokens.valid       = (burst_cnt != 4'd0);
  assign tokens.token_kind  = burst[burst_idx].kind;
  assign tokens.char_value  = burst[burst_idx].value;
  assign tokens.last_of_run = out_last;

  // Control: input slot, lexer state, burst count and read index
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld    <= 1'b0;
      state     <= '0;
      burst_cnt <= 4'd0;
      burst_idx <= 3'd0;
    end else begin
      if (chars.valid && chars.ready) begin
        in_vld <= 1'b1;
      end else if (take) begin
        in_vld <= 1'b0;
      end

      if (take) begin
        state <= state_next;
      end

      if (take && step.count != 4'd0) begin
        burst_cnt <= step.count;
        burst_idx <= 3'd0;
      end else if (out_fire) begin
        if (out_last) begin
          burst_cnt <= 4'd0;
        end else begin
          burst_idx <= burst_idx + 3'd1;
        end
      end
    end
  end

  // Payload: hold the byte, load the burst
  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char <= chars.char_code;
      in_eot  <= chars.end_of_text;
    end
    if (take) begin
      for (int i = 0; i < MAX_RES; i++) begin
        burst[i] <= step.list[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    burst_cnt <= 4'd8)
    else $error("burst count above eight");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    tokens.valid |-> ({1'b0, burst_idx} < burst_cnt))
    else $error("burst read index past the count");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !take) |-> tokens.valid)
    else $error("byte held while the burst is empty");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !take) |=> $stable(state))
    else $error("lexer state moved without a byte");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (take && step.count != 4'd0) |=> (tokens.valid && burst_idx == 3'd0))
    else $error("loaded burst does not start at its first result");
`endif

endmodule
